>>> rtl/tsp_pkg.sv
// Shared types and codes for the three-stack shared-pool block.
package tsp_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_BADID = 2'd3;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam int VAL_W = 32;

endpackage

>>> rtl/three_stacks_shared_pool.sv
// A result is registered after the input transfer: the slot memories are read at the transfer
// edge; write-back and the result register load happen as S_ACCESS ends, once no earlier result
// still waits. The read-modify-write through the registered-read slot memories ends before a
// new item is taken (only in S_IDLE). The next item can be taken while a result waits.
// Reset (synchronous, active low) empties all stacks and the pool at once: unallocated slots are
// tracked by a fill count plus a free list, so there is no clearing pass.
module three_stacks_shared_pool
    import tsp_pkg::*;
#(
    parameter int POOL_DEPTH = 1024,
    parameter int NUM_STACKS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [$clog2(NUM_STACKS + 1)-1:0]   i_stack_id,
    input  logic signed [VAL_W-1:0]             i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [VAL_W-1:0]             o_pop_value,
    output t_status                             o_status
);

    localparam int AW     = $clog2(POOL_DEPTH);
    localparam int PW     = AW + 1;
    localparam int TIDXW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] EMPTY = PW'(POOL_DEPTH);

    typedef enum logic {S_IDLE, S_ACCESS} t_state;

    t_state r_state;

    // stack tops and free-list bookkeeping
    logic [PW-1:0]          r_top [NUM_STACKS];
    logic [PW-1:0]          r_free_head;
    logic [PW-1:0]          r_fill;

    // latched operation
    logic                   r_mode;
    logic [TIDXW-1:0]       r_tidx;
    logic [VAL_W-1:0]       r_val;
    t_status                r_status;
    logic [AW-1:0]          r_slot;
    logic                   r_from_free;

    // output register
    logic                   r_ov;
    logic [VAL_W-1:0]       r_pop_value;
    t_status                r_out_status;

    // memories
    logic [VAL_W-1:0]       val_mem  [POOL_DEPTH];
    logic [PW-1:0]          link_mem [POOL_DEPTH];
    logic [VAL_W-1:0]       r_val_rd;
    logic [PW-1:0]          r_link_rd;

    logic                   in_xfer;
    logic                   done;
    logic [TIDXW-1:0]       tidx;
    logic                   bad_id;
    logic [PW-1:0]          cur_top;
    logic                   from_free;
    logic                   pool_full;
    logic [AW-1:0]          slot;
    t_status                status;
    logic                   val_we;
    logic                   link_we;
    logic [PW-1:0]          link_wd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign done        = (r_state == S_ACCESS) && (!r_ov || i_out_ready);

    assign tidx        = i_stack_id[TIDXW-1:0];
    assign bad_id      = (32'(i_stack_id) >= 32'(NUM_STACKS));
    assign cur_top     = bad_id ? EMPTY : r_top[tidx];
    assign from_free   = (r_free_head != EMPTY);
    assign pool_full   = !from_free && (r_fill == EMPTY);

    always_comb begin
        if (i_mode == MODE_POP) begin
            slot = cur_top[AW-1:0];
        end else if (from_free) begin
            slot = r_free_head[AW-1:0];
        end else begin
            slot = r_fill[AW-1:0];
        end
    end

    always_comb begin
        if (bad_id) begin
            status = ST_BADID;
        end else if (i_mode == MODE_POP) begin
            status = (cur_top == EMPTY) ? ST_EMPTY : ST_OK;
        end else begin
            status = pool_full ? ST_FULL : ST_OK;
        end
    end

    // write-back: push stores value and old top; pop threads the slot onto the free list
    assign val_we  = done && (r_status == ST_OK) && (r_mode == MODE_PUSH);
    assign link_we = done && (r_status == ST_OK);
    assign link_wd = (r_mode == MODE_PUSH) ? r_top[r_tidx] : r_free_head;

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[r_slot] <= r_val;
        end
        if (in_xfer) begin
            r_val_rd <= val_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[r_slot] <= link_wd;
        end
        if (in_xfer) begin
            r_link_rd <= link_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_free_head <= EMPTY;
            r_fill      <= '0;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_top[s] <= EMPTY;
            end
        end else begin
            if (done) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state     <= S_ACCESS;
                        r_mode      <= i_mode;
                        r_tidx      <= tidx;
                        r_val       <= i_push_value;
                        r_status    <= status;
                        r_slot      <= slot;
                        r_from_free <= from_free;
                    end
                end
                S_ACCESS: begin
                    if (done) begin
                        r_state      <= S_IDLE;
                        r_out_status <= r_status;
                        if ((r_status == ST_OK) && (r_mode == MODE_POP)) begin
                            r_pop_value <= r_val_rd;
                        end else begin
                            r_pop_value <= '0;
                        end
                        if (r_status == ST_OK) begin
                            if (r_mode == MODE_PUSH) begin
                                r_top[r_tidx] <= PW'(r_slot);
                                if (r_from_free) begin
                                    r_free_head <= r_link_rd;
                                end else begin
                                    r_fill <= r_fill + PW'(1);
                                end
                            end else begin
                                r_top[r_tidx] <= r_link_rd;
                                r_free_head   <= PW'(r_slot);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_out_status;

endmodule
